/* rtl/core/okvt_pkg.sv */
// Package for the ordered key/value table unit.
// Holds the operation codes, field widths and the controller command bundle.
// No dependencies; every other file of the block imports it.
package okvt_pkg;

	localparam int OP_W    = 3;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_ACCESS = 3'd1,
		OP_FIND   = 3'd2,
		OP_ERASE  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef struct packed {
		logic load;
		logic match;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               reject;
	} res_t;

endpackage

/* rtl/core/okvt_req_if.sv */
// Request channel of the ordered key/value table unit.
// Carries valid, ready and one operation; depends on okvt_pkg.
interface okvt_req_if import okvt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, operation, key, value, position, input ready);
	modport sink   (input valid, operation, key, value, position, output ready);
endinterface

/* rtl/core/okvt_rsp_if.sv */
// Response channel of the ordered key/value table unit.
// Carries valid, ready and one result; depends on okvt_pkg.
interface okvt_rsp_if import okvt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [KEY_W-1:0]   result_key;
	logic [VALUE_W-1:0] result_value;
	logic [COUNT_W-1:0] entry_count;
	logic               is_empty;
	logic               full_reject;

	modport source (output valid, found, result_key, result_value, entry_count,
		is_empty, full_reject, input ready);
	modport sink   (input valid, found, result_key, result_value, entry_count,
		is_empty, full_reject, output ready);
endinterface

/* rtl/core/okvt_ctrl.sv */
// Controller of the ordered key/value table unit.
// Sequences load, match and execute steps and owns the response valid flag.
// Depends on okvt_pkg.
module okvt_ctrl import okvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   exec_go;

	assign exec_go   = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE) || exec_go;
	assign rsp_valid = rsp_valid_q;

	assign cmd.load  = req_valid && req_ready;
	assign cmd.match = (state_q == ST_MATCH);
	assign cmd.exec  = exec_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= cmd.load ? ST_MATCH : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/okvt_dp.sv */
// Datapath of the ordered key/value table unit.
// Holds the entry registers, the parallel key compare, the compaction shift
// and the result register; driven by okvt_ctrl commands, depends on okvt_pkg.
module okvt_dp import okvt_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [OP_W-1:0]    operation,
	input  logic [KEY_W-1:0]   key,
	input  logic [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]   position,
	output res_t               res
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [OP_W-1:0]  op_q;
	logic [KW-1:0]    key_q;
	logic [VW-1:0]    val_q;
	logic [POS_W-1:0] pos_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [KW-1:0]    keys_q [CAPACITY];
	logic [VW-1:0]    vals_q [CAPACITY];
	res_t             res_q;

	logic             hit_d;
	logic [IDX_W-1:0] idx_d;
	logic [PW-1:0]    pos_ext;
	logic             pos_ok;
	logic             full;
	logic [IDX_W-1:0] rd_idx;
	logic [KW-1:0]    rd_key;
	logic [VW-1:0]    rd_val;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [VW-1:0]    wr_val;
	logic             shift_en;
	logic [CNT_W-1:0] cnt_d;
	res_t             res_d;

	always_comb begin
		hit_d = 1'b0;
		idx_d = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < count_q) && (keys_q[i] == key_q)) begin
				hit_d = 1'b1;
				idx_d = IDX_W'(i);
			end
		end
	end

	assign pos_ext = PW'(pos_q);
	assign pos_ok  = CMP_W'(pos_q) < CMP_W'(count_q);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign rd_idx  = (op_q == OP_READ) ? pos_ext[IDX_W-1:0] : hit_idx_q;
	assign rd_key  = keys_q[rd_idx];
	assign rd_val  = vals_q[rd_idx];

	always_comb begin
		res_d    = '0;
		wr_en    = 1'b0;
		wr_idx   = count_q[IDX_W-1:0];
		wr_val   = val_q;
		shift_en = 1'b0;
		cnt_d    = count_q;
		unique case (op_q)
			OP_INSERT, OP_ACCESS: begin
				res_d.key = KEY_W'(key_q);
				if (hit_q) begin
					res_d.found = 1'b1;
					wr_idx      = hit_idx_q;
					if (op_q == OP_INSERT) begin
						wr_en     = 1'b1;
						res_d.value = VALUE_W'(val_q);
					end else begin
						res_d.value = VALUE_W'(rd_val);
					end
				end else if (full) begin
					res_d.reject = 1'b1;
				end else begin
					wr_en = 1'b1;
					if (op_q == OP_ACCESS) begin
						wr_val = '0;
					end
					res_d.value = VALUE_W'(wr_val);
					cnt_d       = count_q + 1'b1;
				end
			end
			OP_FIND: begin
				res_d.key = KEY_W'(key_q);
				if (hit_q) begin
					res_d.found = 1'b1;
					res_d.value = VALUE_W'(rd_val);
				end
			end
			OP_ERASE: begin
				res_d.key = KEY_W'(key_q);
				if (hit_q) begin
					res_d.found = 1'b1;
					res_d.value = VALUE_W'(rd_val);
					shift_en    = 1'b1;
					cnt_d       = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				cnt_d = '0;
			end
			OP_READ: begin
				if (pos_ok) begin
					res_d.found = 1'b1;
					res_d.key   = KEY_W'(rd_key);
					res_d.value = VALUE_W'(rd_val);
				end
			end
			default: begin
			end
		endcase
		res_d.count = COUNT_W'(cnt_d);
		res_d.empty = (cnt_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key[KW-1:0];
			val_q <= value[VW-1:0];
			pos_q <= position;
		end
		if (cmd.match) begin
			hit_q     <= hit_d;
			hit_idx_q <= idx_d;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (shift_en && (IDX_W'(g) >= hit_idx_q) && (g < CAPACITY - 1)) begin
					keys_q[g] <= keys_q[(g < CAPACITY - 1) ? g + 1 : g];
					vals_q[g] <= vals_q[(g < CAPACITY - 1) ? g + 1 : g];
				end else if (wr_en && (wr_idx == IDX_W'(g))) begin
					keys_q[g] <= key_q;
					vals_q[g] <= wr_val;
				end
			end
		end
	end

	assign res = res_q;

endmodule

/* rtl/core/ordered_key_value_table_unit.sv */
// Ordered key/value table unit: an associative table of CAPACITY entries kept
// in insertion order. Each request transaction on req carries an operation
// (insert/update, access-or-create, find, erase, clear, read at position), a
// key, a value and a position; each one yields exactly one response
// transaction on rsp with found, key, value, entry count, empty and reject.
// The key is compared with all valid entries at once in the match step, and
// in the execute step one entry is written or the entries above an erased
// one move down. A transaction is latched when accepted, matched in the match
// step and has its response registered in the execute step. A new request is
// taken in the same cycle as the previous one executes, so a new transaction
// overlaps only the write or shift step of the previous one, not its compare.
// When the receiver stalls, the response stays in the output register and
// the unit holds the next request in its execute step until the response is
// taken. Reset empties the table; entry contents are not cleared.
// Depends on okvt_pkg, okvt_req_if, okvt_rsp_if, okvt_ctrl and okvt_dp.
module ordered_key_value_table_unit import okvt_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	okvt_req_if.sink  req,
	okvt_rsp_if.source rsp
);

	cmd_t cmd;
	res_t res;

	okvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	okvt_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (req.operation),
		.key       (req.key),
		.value     (req.value),
		.position  (req.position),
		.res       (res)
	);

	assign rsp.found        = res.found;
	assign rsp.result_key   = res.key;
	assign rsp.result_value = res.value;
	assign rsp.entry_count  = res.count;
	assign rsp.is_empty     = res.empty;
	assign rsp.full_reject  = res.reject;

endmodule
